@@ src/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PLSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define PLSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLSA_ASSERT(lbl, prop)
`define PLSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/plsa_pkg.sv @@
`default_nettype none

package plsa_pkg;

  localparam int unsigned SceneW    = 5;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned DurW      = 16;
  localparam int unsigned CfgDurW   = 12;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TtlW      = 31;
  localparam int unsigned SoftMsW   = 22;
  localparam int unsigned MsPerS    = 1000;

  localparam logic [SceneW-1:0] CLOCK_SCENE   = 5'd1;
  localparam logic [SceneW-1:0] SPLASH_SCENE  = 5'd15;
  localparam logic [SceneW-1:0] THERMAL_SCENE = 5'd16;
  localparam logic [SceneW-1:0] NIGHT_SCENE   = 5'd17;
  localparam logic [SceneW-1:0] OFFLINE_SCENE = 5'd18;

  localparam logic [TtlW-1:0]    HARD_TTL_RST    = 31'd3600000;
  localparam logic [CfgDurW-1:0] DEF_DUR_RST     = 12'd30;
  localparam logic [CfgDurW-1:0] MAX_DUR_RST     = 12'd3600;
  localparam logic [PrioW-1:0]   MAX_PRIO_RST    = 8'd5;

  localparam int unsigned OVR_SPLASH  = 0;
  localparam int unsigned OVR_THERMAL = 1;
  localparam int unsigned OVR_NIGHT   = 2;
  localparam int unsigned OVR_OFFLINE = 3;

  typedef enum logic [2:0] {
    KIND_REQUEST  = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_OVERRIDE = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_TAKE     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_HARD_TTL = 2'd0,
    CFG_DEF_DUR  = 2'd1,
    CFG_MAX_DUR  = 2'd2,
    CFG_MAX_PRIO = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [SceneW-1:0]  scene;
    logic [PrioW-1:0]   prio;
    logic [DurW-1:0]    dur_sec;
    logic               sticky_req;
    logic [TimeW-1:0]   now_ms;
    logic [1:0]         override_sel;
    logic               override_on;
  } item_t;

  typedef struct packed {
    logic [TtlW-1:0]    hard_ttl_ms;
    logic [CfgDurW-1:0] dflt_dur_sec;
    logic [CfgDurW-1:0] max_dur_sec;
    logic [PrioW-1:0]   max_priority;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    logic               pending;
    logic [SceneW-1:0]  resolved_scene;
  } res_t;

  function automatic logic [SceneW-1:0] resolve_scene(input logic [3:0] flags,
                                                      input logic [SceneW-1:0] lease);
    logic [SceneW-1:0] s;
    if (flags[OVR_SPLASH]) s = SPLASH_SCENE;
    else if (flags[OVR_THERMAL]) s = THERMAL_SCENE;
    else if (flags[OVR_NIGHT]) s = NIGHT_SCENE;
    else if (flags[OVR_OFFLINE]) s = OFFLINE_SCENE;
    else s = lease;
    return s;
  endfunction

  function automatic logic is_due(input logic [TimeW-1:0] now,
                                  input logic [TimeW-1:0] deadline);
    logic [TimeW-1:0] diff;
    diff = now - deadline;
    return ~diff[TimeW-1];
  endfunction

endpackage

`default_nettype wire

@@ src/priority_lease_scene_arbiter_unit.sv @@
// An accepted request is held in the input register, and its result in the output register.
// Throughput: one request per cycle; a stalled result holds the input register and tready.
// The lease and override logic settles between the input and output registers.
// Reset: lease at clock scene, priority 0, both deadlines zero, overrides clear, pending set,
// registers at their documented defaults.
`default_nettype none

module priority_lease_scene_arbiter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // scene[4:0], prio[12:5], dur_sec[28:13], sticky_req[29], now_ms[61:30],
  // override_sel[63:62], override_on[64], zero pad[71:65]
  input  wire logic [71:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // accepted[0], pending[1], resolved_scene[6:2], zero pad[7]
  output logic [7:0]       m_axis_tdata
);

  plsa_pkg::cfg_t  cfg_q;
  plsa_pkg::item_t item_q, item_d;
  plsa_pkg::res_t  res;
  plsa_pkg::res_t  out_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            advance;
  logic            s_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.kind         = plsa_pkg::kind_e'(s_axis_tuser);
    item_d.scene        = s_axis_tdata[4:0];
    item_d.prio         = s_axis_tdata[12:5];
    item_d.dur_sec      = s_axis_tdata[28:13];
    item_d.sticky_req   = s_axis_tdata[29];
    item_d.now_ms       = s_axis_tdata[61:30];
    item_d.override_sel = s_axis_tdata[63:62];
    item_d.override_on  = s_axis_tdata[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hard_ttl_ms  <= plsa_pkg::HARD_TTL_RST;
      cfg_q.dflt_dur_sec <= plsa_pkg::DEF_DUR_RST;
      cfg_q.max_dur_sec  <= plsa_pkg::MAX_DUR_RST;
      cfg_q.max_priority <= plsa_pkg::MAX_PRIO_RST;
    end else if (cfg_we_i) begin
      case (plsa_pkg::cfg_reg_e'(cfg_index_i))
        plsa_pkg::CFG_HARD_TTL: cfg_q.hard_ttl_ms  <= cfg_data_i;
        plsa_pkg::CFG_DEF_DUR:  cfg_q.dflt_dur_sec <= cfg_data_i[11:0];
        plsa_pkg::CFG_MAX_DUR:  cfg_q.max_dur_sec  <= cfg_data_i[11:0];
        plsa_pkg::CFG_MAX_PRIO: cfg_q.max_priority <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_take) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) item_q <= item_d;
    if (advance) out_q <= res;
  end

  plsa_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.resolved_scene, out_q.pending, out_q.accepted};

endmodule

`default_nettype wire

@@ src/plsa_core.sv @@
`default_nettype none

`include "assert_macros.svh"

module plsa_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire plsa_pkg::item_t item_i,
  input  wire plsa_pkg::cfg_t  cfg_i,
  output plsa_pkg::res_t       res_o
);

  logic [plsa_pkg::SceneW-1:0]  scene_q, scene_d;
  logic [plsa_pkg::PrioW-1:0]   prio_q, prio_d;
  logic                         sticky_q, sticky_d;
  logic [plsa_pkg::TimeW-1:0]   soft_q, soft_d;
  logic [plsa_pkg::TimeW-1:0]   hard_q, hard_d;
  logic [3:0]                   flags_q, flags_d;
  logic                         dirty_q, dirty_d;

  logic [plsa_pkg::PrioW-1:0]   prio_sat;
  logic [plsa_pkg::DurW-1:0]    dur_pick;
  logic [plsa_pkg::CfgDurW-1:0] dur_cap;
  logic [plsa_pkg::SoftMsW-1:0] soft_ms;
  logic [plsa_pkg::TimeW-1:0]   hard_next;
  logic                         req_ok;
  logic                         soft_late;
  logic                         hard_late;
  logic                         at_default;
  logic                         revert;
  logic [plsa_pkg::SceneW-1:0]  scene_before;
  logic [plsa_pkg::SceneW-1:0]  scene_after;
  logic                         dirty_mid;

  always_comb begin
    prio_sat = (item_i.prio > cfg_i.max_priority) ? cfg_i.max_priority : item_i.prio;
    dur_pick = (item_i.dur_sec == '0) ? plsa_pkg::DurW'(cfg_i.dflt_dur_sec)
                                      : item_i.dur_sec;
    dur_cap  = (dur_pick > plsa_pkg::DurW'(cfg_i.max_dur_sec))
             ? cfg_i.max_dur_sec
             : dur_pick[plsa_pkg::CfgDurW-1:0];
    soft_ms  = plsa_pkg::SoftMsW'(dur_cap) * plsa_pkg::SoftMsW'(plsa_pkg::MsPerS);
    hard_next = item_i.now_ms + plsa_pkg::TimeW'(cfg_i.hard_ttl_ms);
    req_ok   = (prio_sat >= prio_q);

    soft_late  = (soft_q != '0) && plsa_pkg::is_due(item_i.now_ms, soft_q);
    hard_late  = plsa_pkg::is_due(item_i.now_ms, hard_q);
    at_default = (scene_q == plsa_pkg::CLOCK_SCENE) && (prio_q == '0) && !sticky_q;

    scene_d  = scene_q;
    prio_d   = prio_q;
    sticky_d = sticky_q;
    soft_d   = soft_q;
    hard_d   = hard_q;
    flags_d  = flags_q;
    revert   = 1'b0;
    res_o.accepted = 1'b0;

    case (item_i.kind)
      plsa_pkg::KIND_REQUEST: begin
        if (req_ok) begin
          res_o.accepted = 1'b1;
          scene_d  = item_i.scene;
          prio_d   = prio_sat;
          sticky_d = item_i.sticky_req;
          soft_d   = item_i.sticky_req ? '0
                                       : item_i.now_ms + plsa_pkg::TimeW'(soft_ms);
          hard_d   = hard_next;
        end
      end
      plsa_pkg::KIND_TICK: begin
        revert = (soft_late || hard_late) && !at_default;
      end
      plsa_pkg::KIND_OVERRIDE: begin
        flags_d[item_i.override_sel] = item_i.override_on;
      end
      plsa_pkg::KIND_CLEAR: begin
        revert = sticky_q;
      end
      default: begin
      end
    endcase

    if (revert) begin
      scene_d  = plsa_pkg::CLOCK_SCENE;
      prio_d   = '0;
      sticky_d = 1'b0;
      soft_d   = '0;
      hard_d   = hard_next;
    end

    scene_before = plsa_pkg::resolve_scene(flags_q, scene_q);
    scene_after  = plsa_pkg::resolve_scene(flags_d, scene_d);
    dirty_mid    = dirty_q | (scene_after != scene_before);
    dirty_d      = (item_i.kind == plsa_pkg::KIND_TAKE) ? 1'b0 : dirty_mid;

    res_o.pending        = dirty_mid;
    res_o.resolved_scene = scene_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scene_q  <= plsa_pkg::CLOCK_SCENE;
      prio_q   <= '0;
      sticky_q <= 1'b0;
      soft_q   <= '0;
      hard_q   <= '0;
      flags_q  <= '0;
      dirty_q  <= 1'b1;
    end else if (en_i) begin
      scene_q  <= scene_d;
      prio_q   <= prio_d;
      sticky_q <= sticky_d;
      soft_q   <= soft_d;
      hard_q   <= hard_d;
      flags_q  <= flags_d;
      dirty_q  <= dirty_d;
    end
  end

  `PLSA_ASSERT_NEXT(a_take_clears, en_i && (item_i.kind == plsa_pkg::KIND_TAKE), !dirty_q)
  `PLSA_ASSERT_NEXT(a_idle_holds, !en_i,
                    $stable(prio_q) && $stable(flags_q) && $stable(scene_q) && $stable(dirty_q))
  `PLSA_ASSERT(a_sticky_no_soft, !sticky_q || (soft_q == '0))
  `PLSA_ASSERT_NEXT(a_change_marks, en_i && (item_i.kind != plsa_pkg::KIND_TAKE) &&
                    (scene_after != scene_before), dirty_q)

endmodule

`default_nettype wire

@@ test/tb_priority_lease_scene_arbiter_unit.sv @@
`default_nettype none

module tb_priority_lease_scene_arbiter_unit;

  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;
  localparam int unsigned STALL_PCT = 37;

  typedef struct packed {
    logic [2:0]                  kind;
    logic [plsa_pkg::SceneW-1:0] scene;
    logic [plsa_pkg::PrioW-1:0]  prio;
    logic [plsa_pkg::DurW-1:0]   dur;
    logic                        sticky;
    logic [plsa_pkg::TimeW-1:0]  now;
    logic [1:0]                  sel;
    logic                        on;
  } scene_cmd_t;

  typedef struct packed {
    logic                        accepted;
    logic                        pending;
    logic [plsa_pkg::SceneW-1:0] scene;
  } arb_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  priority_lease_scene_arbiter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow registers and lease state
  logic [plsa_pkg::TtlW-1:0]    ttl_ms     = plsa_pkg::HARD_TTL_RST;
  logic [plsa_pkg::CfgDurW-1:0] dflt_dur   = plsa_pkg::DEF_DUR_RST;
  logic [plsa_pkg::CfgDurW-1:0] max_dur    = plsa_pkg::MAX_DUR_RST;
  logic [plsa_pkg::PrioW-1:0]   max_prio   = plsa_pkg::MAX_PRIO_RST;
  logic [plsa_pkg::SceneW-1:0]  ls_scene   = plsa_pkg::CLOCK_SCENE;
  logic [plsa_pkg::PrioW-1:0]   ls_prio    = '0;
  logic                         ls_sticky  = 1'b0;
  logic [plsa_pkg::TimeW-1:0]   soft_dl    = '0;
  logic [plsa_pkg::TimeW-1:0]   hard_dl    = '0;
  logic [3:0]                   ovr_flags  = '0;
  logic                         dirty      = 1'b1;

  scene_cmd_t  event_q[$];
  arb_out_t    resolved_q[$];
  scene_cmd_t  in_flight;
  logic [plsa_pkg::TimeW-1:0] wall_ms = '0;
  bit          steady = 1'b0;
  int unsigned faults = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [plsa_pkg::SceneW-1:0] shown_scene();
    casez (ovr_flags)
      4'b???1: return plsa_pkg::SPLASH_SCENE;
      4'b??10: return plsa_pkg::THERMAL_SCENE;
      4'b?100: return plsa_pkg::NIGHT_SCENE;
      4'b1000: return plsa_pkg::OFFLINE_SCENE;
      default: return ls_scene;
    endcase
  endfunction

  function automatic logic deadline_passed(logic [plsa_pkg::TimeW-1:0] now,
                                           logic [plsa_pkg::TimeW-1:0] dl);
    logic [plsa_pkg::TimeW-1:0] gap;
    gap = now - dl;
    return !gap[plsa_pkg::TimeW-1];
  endfunction

  function automatic void fall_back_to_clock(logic [plsa_pkg::TimeW-1:0] now);
    ls_scene  = plsa_pkg::CLOCK_SCENE;
    ls_prio   = '0;
    ls_sticky = 1'b0;
    soft_dl   = '0;
    hard_dl   = now + ttl_ms;
  endfunction

  function automatic arb_out_t arbitrate(scene_cmd_t c);
    arb_out_t                    r;
    logic [plsa_pkg::SceneW-1:0] was;
    logic [plsa_pkg::PrioW-1:0]  p;
    int unsigned                 secs;
    logic                        soft_hit;
    logic                        hard_hit;
    r.accepted = 1'b0;
    was = shown_scene();
    case (c.kind)
      plsa_pkg::KIND_REQUEST: begin
        p = (c.prio > max_prio) ? max_prio : c.prio;
        secs = 0;
        if (!c.sticky) begin
          secs = (c.dur == '0) ? 32'(dflt_dur) : 32'(c.dur);
          if (secs > 32'(max_dur)) secs = 32'(max_dur);
        end
        if (p >= ls_prio) begin
          r.accepted = 1'b1;
          ls_scene   = c.scene;
          ls_prio    = p;
          ls_sticky  = c.sticky;
          soft_dl    = c.sticky ? '0 : c.now + secs * plsa_pkg::MsPerS;
          hard_dl    = c.now + ttl_ms;
        end
      end
      plsa_pkg::KIND_TICK: begin
        soft_hit = soft_dl != '0 && deadline_passed(c.now, soft_dl);
        hard_hit = deadline_passed(c.now, hard_dl);
        if ((soft_hit || hard_hit) &&
            !(ls_scene == plsa_pkg::CLOCK_SCENE && ls_prio == '0 && !ls_sticky)) begin
          fall_back_to_clock(c.now);
        end
      end
      plsa_pkg::KIND_OVERRIDE: ovr_flags[c.sel] = c.on;
      plsa_pkg::KIND_CLEAR: begin
        if (ls_sticky) fall_back_to_clock(c.now);
      end
      default: ;
    endcase
    if (shown_scene() != was) dirty = 1'b1;
    r.pending = dirty;
    if (c.kind == plsa_pkg::KIND_TAKE) dirty = 1'b0;
    r.scene = shown_scene();
    return r;
  endfunction

  function automatic scene_cmd_t make_event();
    scene_cmd_t  c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) c.kind = plsa_pkg::KIND_REQUEST;
    else if (roll < 63) c.kind = plsa_pkg::KIND_TICK;
    else if (roll < 75) c.kind = plsa_pkg::KIND_OVERRIDE;
    else if (roll < 83) c.kind = plsa_pkg::KIND_CLEAR;
    else if (roll < 96) c.kind = plsa_pkg::KIND_TAKE;
    else c.kind = 3'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO));
    c.scene = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(4, 2));
    c.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    roll = $urandom_range(9);
    if (roll < 3) c.dur = '0;
    else if (roll < 8) c.dur = 16'($urandom_range(4000, 1));
    else c.dur = 16'($urandom);
    c.sticky = ($urandom_range(3) == 0);
    roll = $urandom_range(19);
    if (roll < 12) wall_ms += $urandom_range(5000);
    else if (roll < 18) wall_ms += $urandom_range(400000);
    else wall_ms += $urandom_range(8000000);
    c.now = ($urandom_range(19) == 0) ? $urandom : wall_ms;
    c.sel = 2'($urandom);
    c.on = 1'($urandom);
    return c;
  endfunction

  task automatic post(logic [2:0] kind, logic [plsa_pkg::SceneW-1:0] scene,
                      logic [plsa_pkg::PrioW-1:0] prio, logic [plsa_pkg::DurW-1:0] dur,
                      logic sticky, logic [plsa_pkg::TimeW-1:0] now,
                      logic [1:0] sel = '0, logic on = 1'b0);
    scene_cmd_t c;
    c = '{kind, scene, prio, dur, sticky, now, sel, on};
    event_q.push_back(c);
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || resolved_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_reg(plsa_pkg::cfg_reg_e idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      plsa_pkg::CFG_HARD_TTL: ttl_ms   = val[plsa_pkg::TtlW-1:0];
      plsa_pkg::CFG_DEF_DUR:  dflt_dur = val[plsa_pkg::CfgDurW-1:0];
      plsa_pkg::CFG_MAX_DUR:  max_dur  = val[plsa_pkg::CfgDurW-1:0];
      plsa_pkg::CFG_MAX_PRIO: max_prio = val[plsa_pkg::PrioW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [30:0] ttl, logic [30:0] dflt, logic [30:0] maxd,
                           logic [30:0] maxp);
    set_reg(plsa_pkg::CFG_HARD_TTL, ttl);
    set_reg(plsa_pkg::CFG_DEF_DUR, dflt);
    set_reg(plsa_pkg::CFG_MAX_DUR, maxd);
    set_reg(plsa_pkg::CFG_MAX_PRIO, maxp);
  endtask

  task automatic burst(int unsigned n, bit calm);
    steady = calm;
    repeat (n) event_q.push_back(make_event());
    settle();
    steady = 1'b0;
  endtask

  // request driver
  always @(posedge clk_i) begin
    logic busy;
    busy = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        resolved_q.push_back(arbitrate(in_flight));
        busy = 1'b0;
      end
      if (!busy && event_q.size() != 0 && (steady || $urandom_range(99) >= STALL_PCT)) begin
        in_flight = event_q.pop_front();
        s_axis_tuser <= in_flight.kind;
        s_axis_tdata <= {7'd0, in_flight.on, in_flight.sel, in_flight.now, in_flight.sticky,
                         in_flight.dur, in_flight.prio, in_flight.scene};
        busy = 1'b1;
      end
      s_axis_tvalid <= busy;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    arb_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (resolved_q.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          faults++;
        end else begin
          want = resolved_q.pop_front();
          if (m_axis_tdata[0] !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, m_axis_tdata[0]);
            faults++;
          end
          if (m_axis_tdata[1] !== want.pending) begin
            $error("pending: expected %0d, got %0d", want.pending, m_axis_tdata[1]);
            faults++;
          end
          if (m_axis_tdata[6:2] !== want.scene) begin
            $error("resolved_scene: expected %0d, got %0d", want.scene, m_axis_tdata[6:2]);
            faults++;
          end
        end
      end
      m_axis_tready <= steady || $urandom_range(99) >= STALL_PCT;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    post(plsa_pkg::KIND_TAKE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0);
    post(plsa_pkg::KIND_TAKE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0);
    post(plsa_pkg::KIND_REQUEST, 5'd7, 8'd255, 16'd0, 1'b0, 32'd1000);
    post(plsa_pkg::KIND_REQUEST, 5'd7, 8'd9, 16'd0, 1'b0, 32'd2000);
    post(plsa_pkg::KIND_REQUEST, 5'd9, 8'd4, 16'd100, 1'b0, 32'd3000);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'd31999);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'd32000);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'd9000000);
    post(plsa_pkg::KIND_REQUEST, 5'd31, 8'd3, 16'hFFFF, 1'b1, 32'd9000100);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'd9500000);
    post(plsa_pkg::KIND_CLEAR, 5'd0, 8'd0, 16'd0, 1'b0, 32'd9600000);
    post(plsa_pkg::KIND_CLEAR, 5'd0, 8'd0, 16'd0, 1'b0, 32'd9700000);
    post(plsa_pkg::KIND_REQUEST, 5'd0, 8'd0, 16'hFFFF, 1'b0, 32'd9800000);
    for (int s = int'(plsa_pkg::OVR_OFFLINE); s >= int'(plsa_pkg::OVR_SPLASH); s--) begin
      post(plsa_pkg::KIND_OVERRIDE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0, 2'(s), 1'b1);
    end
    post(plsa_pkg::KIND_OVERRIDE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0,
         2'(plsa_pkg::OVR_THERMAL), 1'b0);
    post(plsa_pkg::KIND_OVERRIDE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0,
         2'(plsa_pkg::OVR_SPLASH), 1'b0);
    post(plsa_pkg::KIND_OVERRIDE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0,
         2'(plsa_pkg::OVR_NIGHT), 1'b0);
    post(plsa_pkg::KIND_OVERRIDE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0,
         2'(plsa_pkg::OVR_OFFLINE), 1'b0);
    for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++) begin
      post(3'(k), 5'h1F, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 2'b11, 1'b1);
    end
    post(plsa_pkg::KIND_TAKE, 5'd0, 8'd0, 16'd0, 1'b0, 32'd0);
    // soft deadline wraps onto zero: only the hard deadline counts
    post(plsa_pkg::KIND_REQUEST, 5'd5, 8'd5, 16'd30, 1'b0, 32'hFFFF_8AD0);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'h0000_1000);
    post(plsa_pkg::KIND_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 32'h0040_0000);
    post(plsa_pkg::KIND_REQUEST, 5'h1F, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 2'b11, 1'b1);
    settle();

    configure(31'd1, 31'd1, 31'd3600, 31'd255);
    burst(150, 1'b0);
    configure(31'h7FFF_FFFF, 31'd3600, 31'd1, 31'd0);
    burst(150, 1'b0);
    configure(31'($urandom_range(5000000, 1000)), 31'($urandom_range(3600, 1)),
              31'($urandom_range(3600, 1)), 31'($urandom_range(8)));
    burst(150, 1'b1);
    configure(31'(plsa_pkg::HARD_TTL_RST), 31'(plsa_pkg::DEF_DUR_RST),
              31'(plsa_pkg::MAX_DUR_RST), 31'(plsa_pkg::MAX_PRIO_RST));
    wall_ms = 32'hFFF0_0000;
    burst(200, 1'b0);
    configure(31'($urandom_range(400000, 1)), 31'($urandom_range(3600, 1)),
              31'($urandom_range(3600, 1)), 31'($urandom_range(255)));
    burst(150, 1'b0);

    repeat (10) @(posedge clk_i);
    if (resolved_q.size() != 0) begin
      $error("%0d results never arrived", resolved_q.size());
      faults++;
    end
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/plsa_pkg.sv
src/plsa_core.sv
src/priority_lease_scene_arbiter_unit.sv
test/tb_priority_lease_scene_arbiter_unit.sv
